// ===== rtl/core/fst_pkg.sv =====
// Shared types, constants and decode helpers for the format specifier tokeniser.
`default_nettype none

package fst_pkg;

  // Width and precision accumulators wrap at this many bits.
  localparam int unsigned CountBits = 16;
  localparam int unsigned FieldW    = 16;
  localparam int unsigned FlagW     = 6;

  // Flag masks, as held in the flag register.
  localparam logic [FlagW-1:0] FLeft  = 6'h01;
  localparam logic [FlagW-1:0] FHash  = 6'h02;
  localparam logic [FlagW-1:0] FZero  = 6'h04;
  localparam logic [FlagW-1:0] FLong  = 6'h08;
  localparam logic [FlagW-1:0] FShort = 6'h10;
  localparam logic [FlagW-1:0] FUpper = 6'h20;

  // Pointer conversions always print this many digits.
  localparam logic [FieldW-1:0] PtrWidth = 16'd8;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLow   = 8'h6c;  // 'l'
  localparam logic [7:0] ChHalf  = 8'h68;  // 'h'
  localparam logic [7:0] ChPtr   = 8'h70;  // 'p'
  localparam logic [7:0] ChHexUp = 8'h58;  // 'X'

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PCT   = 3'd1,
    PH_MINUS = 3'd2,
    PH_HASH  = 3'd3,
    PH_WIDTH = 3'd4,
    PH_PREC  = 3'd5,
    PH_TYPE  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    ARG_CHAR     = 3'd0,
    ARG_STRING   = 3'd1,
    ARG_SIGNED   = 3'd2,
    ARG_UNSIGNED = 3'd3,
    ARG_HEX      = 3'd4
  } arg_e;

  typedef enum logic [3:0] {
    ACT_END,
    ACT_RESTART,
    ACT_PCT_LIT,
    ACT_LEFT,
    ACT_HASH,
    ACT_ZERO,
    ACT_WDIGIT,
    ACT_DOT,
    ACT_PDIGIT,
    ACT_MOD,
    ACT_TYPE
  } act_e;

  typedef struct packed {
    phase_e               phase;
    logic [FlagW-1:0]     flags;
    logic [CountBits-1:0] width_acc;
    logic [CountBits-1:0] prec_acc;
  } fst_state_t;

  typedef struct packed {
    logic              is_spec;
    logic [7:0]        literal_char;
    logic [FlagW-1:0]  flags;
    logic [FieldW-1:0] field_width;
    logic [FieldW-1:0] field_precision;
    arg_e              arg_type;
  } fst_token_t;

  typedef struct packed {
    logic hit;
    arg_e code;
  } type_dec_t;

  function automatic type_dec_t decode_type(input logic [7:0] c);
    type_dec_t d;
    d.hit  = 1'b1;
    d.code = ARG_CHAR;
    unique case (c)
      8'h63, 8'h43: d.code = ARG_CHAR;      // c C
      8'h73, 8'h53: d.code = ARG_STRING;    // s S
      8'h64, 8'h69: d.code = ARG_SIGNED;    // d i
      8'h75:        d.code = ARG_UNSIGNED;  // u
      8'h78, 8'h58, 8'h70: d.code = ARG_HEX;  // x X p
      default: d.hit = 1'b0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fst_step.sv =====
// Combinational parser step: one byte against the current phase and partial specifier.
`default_nettype none

module fst_step import fst_pkg::*; (
  input  logic [7:0] ch_i,
  input  fst_state_t state_i,
  output fst_state_t state_o,
  output logic       emit_o,
  output fst_token_t token_o
);

  act_e                 act;
  phase_e               phase_d;
  logic [FlagW-1:0]     flags_d;
  logic [CountBits-1:0] width_d;
  logic [CountBits-1:0] prec_d;
  logic                 is_digit;
  logic                 is_mod;
  type_dec_t            tdec;
  logic [CountBits-1:0] digit_val;
  logic [CountBits-1:0] width_next;
  logic [CountBits-1:0] prec_next;
  logic [FlagW-1:0]     spec_flags;

  assign is_digit  = (ch_i >= ChZero) && (ch_i <= ChNine);
  assign is_mod    = (ch_i == ChLow) || (ch_i == ChHalf);
  assign tdec      = decode_type(ch_i);
  assign digit_val = CountBits'(ch_i[3:0]);

  // Times ten as two shifts and an add.
  assign width_next = (state_i.width_acc << 3) + (state_i.width_acc << 1) + digit_val;
  assign prec_next  = (state_i.prec_acc << 3) + (state_i.prec_acc << 1) + digit_val;

  // Classify the byte. The flag order is enforced by which phases accept which flag.
  always_comb begin
    act = ACT_RESTART;
    if (ch_i == ChNul) begin
      act = ACT_END;
    end else begin
      unique case (state_i.phase)
        PH_PCT: begin
          priority if (ch_i == ChPct)   act = ACT_PCT_LIT;
          else if (ch_i == ChMinus)     act = ACT_LEFT;
          else if (ch_i == ChHash)      act = ACT_HASH;
          else if (ch_i == ChZero)      act = ACT_ZERO;
          else if (is_digit)            act = ACT_WDIGIT;
          else if (ch_i == ChDot)       act = ACT_DOT;
          else if (is_mod)              act = ACT_MOD;
          else if (tdec.hit)            act = ACT_TYPE;
          else                          act = ACT_RESTART;
        end
        PH_MINUS: begin
          priority if (ch_i == ChHash)  act = ACT_HASH;
          else if (ch_i == ChZero)      act = ACT_ZERO;
          else if (is_digit)            act = ACT_WDIGIT;
          else if (ch_i == ChDot)       act = ACT_DOT;
          else if (is_mod)              act = ACT_MOD;
          else if (tdec.hit)            act = ACT_TYPE;
          else                          act = ACT_RESTART;
        end
        PH_HASH: begin
          priority if (ch_i == ChZero)  act = ACT_ZERO;
          else if (is_digit)            act = ACT_WDIGIT;
          else if (ch_i == ChDot)       act = ACT_DOT;
          else if (is_mod)              act = ACT_MOD;
          else if (tdec.hit)            act = ACT_TYPE;
          else                          act = ACT_RESTART;
        end
        PH_WIDTH: begin
          priority if (is_digit)        act = ACT_WDIGIT;
          else if (ch_i == ChDot)       act = ACT_DOT;
          else if (is_mod)              act = ACT_MOD;
          else if (tdec.hit)            act = ACT_TYPE;
          else                          act = ACT_RESTART;
        end
        PH_PREC: begin
          priority if (is_digit)        act = ACT_PDIGIT;
          else if (is_mod)              act = ACT_MOD;
          else if (tdec.hit)            act = ACT_TYPE;
          else                          act = ACT_RESTART;
        end
        PH_TYPE: begin
          if (tdec.hit) act = ACT_TYPE;
          else          act = ACT_RESTART;
        end
        default: act = ACT_RESTART;
      endcase
    end
  end

  // Next phase.
  always_comb begin
    unique case (act)
      ACT_END:     phase_d = PH_IDLE;
      ACT_RESTART: phase_d = (ch_i == ChPct) ? PH_PCT : PH_IDLE;
      ACT_PCT_LIT: phase_d = PH_IDLE;
      ACT_LEFT:    phase_d = PH_MINUS;
      ACT_HASH:    phase_d = PH_HASH;
      ACT_ZERO:    phase_d = PH_WIDTH;
      ACT_WDIGIT:  phase_d = PH_WIDTH;
      ACT_DOT:     phase_d = PH_PREC;
      ACT_PDIGIT:  phase_d = PH_PREC;
      ACT_MOD:     phase_d = PH_TYPE;
      ACT_TYPE:    phase_d = PH_IDLE;
      default:     phase_d = PH_IDLE;
    endcase
  end

  // Pointer type forces zero pad and upper case; upper case X sets upper case only.
  always_comb begin
    spec_flags = state_i.flags;
    if (ch_i == ChPtr)   spec_flags = spec_flags | FZero | FUpper;
    if (ch_i == ChHexUp) spec_flags = spec_flags | FUpper;
  end

  // Accumulators, flags and the token.
  always_comb begin
    flags_d = state_i.flags;
    width_d = state_i.width_acc;
    prec_d  = state_i.prec_acc;
    emit_o  = 1'b0;
    token_o = '0;
    unique case (act)
      ACT_END: begin
        flags_d = '0;
        width_d = '0;
        prec_d  = '0;
      end
      ACT_RESTART: begin
        flags_d = '0;
        width_d = '0;
        prec_d  = '0;
        if (ch_i != ChPct) begin
          emit_o               = 1'b1;
          token_o.literal_char = ch_i;
        end
      end
      ACT_PCT_LIT: begin
        flags_d              = '0;
        width_d              = '0;
        prec_d               = '0;
        emit_o               = 1'b1;
        token_o.literal_char = ch_i;
      end
      ACT_LEFT:   flags_d = state_i.flags | FLeft;
      ACT_HASH:   flags_d = state_i.flags | FHash;
      ACT_ZERO:   flags_d = state_i.flags | FZero;
      ACT_WDIGIT: width_d = width_next;
      ACT_DOT:    ;
      ACT_PDIGIT: prec_d = prec_next;
      ACT_MOD:    flags_d = state_i.flags | ((ch_i == ChLow) ? FLong : FShort);
      ACT_TYPE: begin
        flags_d                 = '0;
        width_d                 = '0;
        prec_d                  = '0;
        emit_o                  = 1'b1;
        token_o.is_spec         = 1'b1;
        token_o.flags           = spec_flags;
        token_o.field_width     = (ch_i == ChPtr) ? PtrWidth
                                                  : FieldW'(state_i.width_acc);
        token_o.field_precision = FieldW'(state_i.prec_acc);
        token_o.arg_type        = tdec.code;
      end
      default: ;
    endcase
  end

  assign state_o = '{phase: phase_d, flags: flags_d, width_acc: width_d, prec_acc: prec_d};

endmodule

`default_nettype wire

// ===== rtl/core/format_spec_tokenizer.sv =====
// Each byte is parsed from the input register and its token is held in the result register.
// Throughput: one byte per cycle while the result register is free or being drained.
// An input register and a result register part the two sides, so a waiting token does not
// stop the next byte from being taken while the result register is free or being drained.
// Reset clears both valid flags, the phase (to idle), the flags and both accumulators.
`default_nettype none

module format_spec_tokenizer import fst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        ch_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              is_spec_o,
  output logic [7:0]        literal_char_o,
  output logic              left_align_o,
  output logic              prefix_hex_o,
  output logic              zero_pad_o,
  output logic              long_arg_o,
  output logic              short_arg_o,
  output logic              upper_hex_o,
  output logic [FieldW-1:0] field_width_o,
  output logic [FieldW-1:0] field_precision_o,
  output logic [2:0]        arg_type_o
);

  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       out_valid_q;
  fst_token_t tok_q;
  fst_state_t state_q;
  fst_state_t state_d;
  fst_token_t tok_d;
  logic       emit;
  logic       adv;
  logic       step;

  // The parse stage moves on whenever the result register is empty or being drained.
  assign adv        = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && adv;
  assign in_ready_o = !in_valid_q || adv;

  fst_step u_step (
    .ch_i    (ch_q),
    .state_i (state_q),
    .state_o (state_d),
    .emit_o  (emit),
    .token_o (tok_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: PH_IDLE, flags: '0, width_acc: '0, prec_acc: '0};
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (adv)        out_valid_q <= in_valid_q && emit;
      if (step)       state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) ch_q <= ch_i;
    if (step && emit)             tok_q <= tok_d;
  end

  assign out_valid_o       = out_valid_q;
  assign is_spec_o         = tok_q.is_spec;
  assign literal_char_o    = tok_q.literal_char;
  assign left_align_o      = |(tok_q.flags & FLeft);
  assign prefix_hex_o      = |(tok_q.flags & FHash);
  assign zero_pad_o        = |(tok_q.flags & FZero);
  assign long_arg_o        = |(tok_q.flags & FLong);
  assign short_arg_o       = |(tok_q.flags & FShort);
  assign upper_hex_o       = |(tok_q.flags & FUpper);
  assign field_width_o     = tok_q.field_width;
  assign field_precision_o = tok_q.field_precision;
  assign arg_type_o        = tok_q.arg_type;

`ifndef NO_ASSERTIONS
  // A literal beat carries nothing but its byte.
  a_literal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_spec_o |-> (tok_q.flags == '0) && (field_width_o == '0)
      && (field_precision_o == '0) && (arg_type_o == ARG_CHAR))
    else $error("literal token carries specifier fields");

  // Upper case digits only ever come with a hex conversion.
  a_upper_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_spec_o && upper_hex_o |-> arg_type_o == ARG_HEX)
    else $error("upper hex flag on a non-hex specifier");

  // A terminating zero byte discards any partial specifier.
  a_nul_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (ch_q == ChNul) |=> (state_q.phase == PH_IDLE) && (state_q.flags == '0)
      && (state_q.width_acc == '0) && (state_q.prec_acc == '0))
    else $error("zero byte did not return the parser to idle");

  // The partial specifier only changes when a byte is processed.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(state_q))
    else $error("parser state changed without a byte");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the format specifier tokeniser, with bursty input and stalled output.
`timescale 1ns / 100ps

module testbench;
  import fst_pkg::*;

  localparam int RandomBytes = 2000;
  localparam int LongHold    = 400;
  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 16;

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    bit         emits;
    fst_token_t tok;
  } byte_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [7:0]        ch_i = 8'h00;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              is_spec_o;
  logic [7:0]        literal_char_o;
  logic              left_align_o;
  logic              prefix_hex_o;
  logic              zero_pad_o;
  logic              long_arg_o;
  logic              short_arg_o;
  logic              upper_hex_o;
  logic [FieldW-1:0] field_width_o;
  logic [FieldW-1:0] field_precision_o;
  logic [2:0]        arg_type_o;

  byte_row_t  format_bytes[$];
  fst_token_t expected_tokens[$];
  int         mismatches = 0;
  bit         draining = 1'b0;

  // Shadow of the tokeniser state.
  phase_e               tk_phase = PH_IDLE;
  logic [FlagW-1:0]     tk_flags = '0;
  logic [CountBits-1:0] tk_width = '0;
  logic [CountBits-1:0] tk_prec = '0;

  format_spec_tokenizer DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .ch_i              (ch_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .is_spec_o         (is_spec_o),
    .literal_char_o    (literal_char_o),
    .left_align_o      (left_align_o),
    .prefix_hex_o      (prefix_hex_o),
    .zero_pad_o        (zero_pad_o),
    .long_arg_o        (long_arg_o),
    .short_arg_o       (short_arg_o),
    .upper_hex_o       (upper_hex_o),
    .field_width_o     (field_width_o),
    .field_precision_o (field_precision_o),
    .arg_type_o        (arg_type_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic fst_token_t literal_token(input logic [7:0] c);
    fst_token_t t;
    t = '0;
    t.literal_char = c;
    return t;
  endfunction

  function automatic fst_token_t spec_token(input logic [FlagW-1:0] flags,
                                            input logic [FieldW-1:0] w,
                                            input logic [FieldW-1:0] p, input arg_e arg);
    fst_token_t t;
    t = '0;
    t.is_spec         = 1'b1;
    t.flags           = flags;
    t.field_width     = w;
    t.field_precision = p;
    t.arg_type        = arg;
    return t;
  endfunction

  function automatic void clear_spec();
    tk_flags = '0;
    tk_width = '0;
    tk_prec  = '0;
  endfunction

  // A byte with no specifier open, or in place of a known type: '%' opens one, anything else is copied out.
  function automatic bit restart_byte(input logic [7:0] c, output fst_token_t tok);
    clear_spec();
    if (c == ChPct) begin
      tk_phase = PH_PCT;
      return 1'b0;
    end
    tk_phase = PH_IDLE;
    tok = literal_token(c);
    return 1'b1;
  endfunction

  // Advances the shadow state by one byte; returns whether a token comes out.
  function automatic bit tokenize_byte(input logic [7:0] c, output fst_token_t tok);
    bit   digit;
    bit   known;
    arg_e code;
    digit = (c >= ChZero) && (c <= ChNine);
    tok   = '0;
    known = 1'b1;
    code  = ARG_CHAR;
    if (c == ChNul) begin
      clear_spec();
      tk_phase = PH_IDLE;
      return 1'b0;
    end
    if (tk_phase == PH_IDLE || tk_phase > PH_TYPE) return restart_byte(c, tok);
    if (tk_phase == PH_PCT && c == ChPct) begin
      clear_spec();
      tk_phase = PH_IDLE;
      tok = literal_token(c);
      return 1'b1;
    end
    if (tk_phase == PH_PCT && c == ChMinus) begin
      tk_flags |= FLeft;
      tk_phase = PH_MINUS;
      return 1'b0;
    end
    if ((tk_phase == PH_PCT || tk_phase == PH_MINUS) && c == ChHash) begin
      tk_flags |= FHash;
      tk_phase = PH_HASH;
      return 1'b0;
    end
    if (tk_phase inside {PH_PCT, PH_MINUS, PH_HASH} && c == ChZero) begin
      tk_flags |= FZero;
      tk_phase = PH_WIDTH;
      return 1'b0;
    end
    if (tk_phase <= PH_WIDTH && digit) begin
      tk_width = tk_width * 16'd10 + {8'd0, c - ChZero};
      tk_phase = PH_WIDTH;
      return 1'b0;
    end
    if (tk_phase <= PH_WIDTH && c == ChDot) begin
      tk_phase = PH_PREC;
      return 1'b0;
    end
    if (tk_phase == PH_PREC && digit) begin
      tk_prec = tk_prec * 16'd10 + {8'd0, c - ChZero};
      return 1'b0;
    end
    if (tk_phase <= PH_PREC && (c == ChLow || c == ChHalf)) begin
      tk_flags |= (c == ChLow) ? FLong : FShort;
      tk_phase = PH_TYPE;
      return 1'b0;
    end
    case (c)
      "c", "C": code = ARG_CHAR;
      "s", "S": code = ARG_STRING;
      "d", "i": code = ARG_SIGNED;
      "u":      code = ARG_UNSIGNED;
      "x":      code = ARG_HEX;
      "X": begin
        tk_flags |= FUpper;
        code = ARG_HEX;
      end
      "p": begin
        tk_flags |= FZero | FUpper;
        tk_width = PtrWidth;
        code = ARG_HEX;
      end
      default: known = 1'b0;
    endcase
    if (!known) return restart_byte(c, tok);
    tok = spec_token(tk_flags, tk_width, tk_prec, code);
    clear_spec();
    tk_phase = PH_IDLE;
    return 1'b1;
  endfunction

  function automatic void add_typed(input logic [7:0] c, input bit emits, input fst_token_t tok);
    byte_row_t r;
    r.ch    = c;
    r.typed = 1'b1;
    r.emits = emits;
    r.tok   = tok;
    format_bytes.push_back(r);
  endfunction

  function automatic void add_byte(input logic [7:0] c);
    byte_row_t r;
    r.ch    = c;
    r.typed = 1'b0;
    r.emits = 1'b0;
    r.tok   = '0;
    format_bytes.push_back(r);
  endfunction

  function automatic void load_directed();
    add_typed("A", 1'b1, literal_token("A"));
    add_typed(8'hff, 1'b1, literal_token(8'hff));
    add_typed(8'h01, 1'b1, literal_token(8'h01));
    add_typed(ChNul, 1'b0, '0);
    // Doubled percent.
    add_byte(ChPct);
    add_typed(ChPct, 1'b1, literal_token(ChPct));
    // All three flags, a second zero taken as a width digit, precision and a short modifier.
    add_byte(ChPct);
    add_byte(ChMinus);
    add_byte(ChHash);
    add_byte(ChZero);
    add_byte(ChZero);
    add_byte("7");
    add_byte(ChDot);
    add_byte("9");
    add_byte(ChHalf);
    add_byte(ChHexUp);
    add_byte(ChPct);
    add_typed(ChPtr, 1'b1, spec_token(FZero | FUpper, PtrWidth, '0, ARG_HEX));
    // An unknown type byte falls back to a literal.
    add_byte(ChPct);
    add_byte("9");
    add_typed("q", 1'b1, literal_token("q"));
    // A zero byte drops the open specifier.
    add_byte(ChPct);
    add_byte(ChZero);
    add_typed(ChNul, 1'b0, '0);
    // A percent in place of the type restarts the specifier and forgets the modifier.
    add_byte(ChPct);
    add_byte(ChLow);
    add_byte(ChPct);
    add_typed("c", 1'b1, spec_token('0, '0, '0, ARG_CHAR));
  endfunction

  function automatic void add_digits(input int n);
    repeat (n) add_byte(ChZero + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void load_random();
    string type_chars;
    int    stop;
    int    pick;
    logic [7:0] b;
    type_chars = "cCsSdiuxXp";
    stop = format_bytes.size() + RandomBytes;
    while (format_bytes.size() < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        add_byte(ChPct);
        if ($urandom_range(0, 2) == 0) add_byte(ChMinus);
        if ($urandom_range(0, 2) == 0) add_byte(ChHash);
        if ($urandom_range(0, 2) == 0) add_byte(ChZero);
        // Now and then a long run of digits, so that the accumulators wrap.
        if ($urandom_range(0, 9) == 0) add_digits($urandom_range(5, 8));
        else add_digits($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1) begin
          add_byte(ChDot);
          if ($urandom_range(0, 9) == 0) add_digits($urandom_range(5, 7));
          else add_digits($urandom_range(0, 3));
        end
        case ($urandom_range(0, 2))
          0: add_byte(ChLow);
          1: add_byte(ChHalf);
          default: ;
        endcase
        if ($urandom_range(0, 19) == 0) add_byte(ChNul);
        else if ($urandom_range(0, 7) == 0) add_byte(8'($urandom_range(1, 255)));
        else add_byte(type_chars[$urandom_range(0, type_chars.len() - 1)]);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) begin
          b = 8'($urandom_range(1, 255));
          add_byte(b);
          if (b == ChPct) add_byte(ChPct);
        end
      end else if (pick < 95) begin
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_byte(ChNul);
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) report_mismatch($sformatf("%s: expected %0h, got %0h", name, want, got));
  endtask

  always @(posedge clk_i) begin : token_monitor
    fst_token_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("token beat with none expected");
      end else begin
        want = expected_tokens.pop_front();
        check_field("is_spec", 16'(want.is_spec), 16'(is_spec_o));
        check_field("literal_char", 16'(want.literal_char), 16'(literal_char_o));
        check_field("left_align", 16'((want.flags & FLeft) != 0), 16'(left_align_o));
        check_field("prefix_hex", 16'((want.flags & FHash) != 0), 16'(prefix_hex_o));
        check_field("zero_pad", 16'((want.flags & FZero) != 0), 16'(zero_pad_o));
        check_field("long_arg", 16'((want.flags & FLong) != 0), 16'(long_arg_o));
        check_field("short_arg", 16'((want.flags & FShort) != 0), 16'(short_arg_o));
        check_field("upper_hex", 16'((want.flags & FUpper) != 0), 16'(upper_hex_o));
        check_field("field_width", want.field_width, field_width_o);
        check_field("field_precision", want.field_precision, field_precision_o);
        check_field("arg_type", 16'(want.arg_type), 16'(arg_type_o));
      end
    end
  end

  // The receiver picks a new manner for each segment of its run, and once holds off for a long stretch
  // so that the tokeniser backs up and stops taking bytes.
  initial begin : receiver
    int seg;
    int mode;
    int tick;
    seg  = 0;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      if (seg == 12 && !draining) begin
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        repeat (32) begin
          tick++;
          if (draining || mode == 0) out_ready_i <= 1'b1;
          else if (mode == 1) out_ready_i <= 1'($urandom_range(0, 1));
          else if (mode == 2) out_ready_i <= ($urandom_range(0, 3) == 0);
          else out_ready_i <= (tick % 3 != 0);
          @(posedge clk_i);
        end
      end
      seg++;
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stalled = 0;
      else stalled++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : sender
    byte_row_t  row;
    fst_token_t tok;
    bit         emits;
    int         burst_left;
    int         gap;
    load_directed();
    load_random();
    burst_left = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    foreach (format_bytes[i]) begin
      row = format_bytes[i];
      if (burst_left == 0) begin
        if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(50, 200);
        else burst_left = $urandom_range(1, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      in_valid_i <= 1'b1;
      ch_i       <= row.ch;
      do @(posedge clk_i); while (!in_ready_o);
      // The beat has been taken at this edge.
      emits = tokenize_byte(row.ch, tok);
      if (row.typed) begin
        emits = row.emits;
        tok   = row.tok;
      end
      if (emits) expected_tokens.push_back(tok);
    end
    in_valid_i <= 1'b0;
    draining = 1'b1;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
